>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spectrum peak class folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must never hold
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_NEVER(name, clk, rst, cond)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> hdl/spcf_pkg.sv
// ----------------------------------------------------------------------------
// spcf_pkg
// Types and constants shared by the spectrum peak class folder modules.
// ----------------------------------------------------------------------------
package spcf_pkg;

   localparam int MAG_W       = 32;
   localparam int TAG_W       = 12;
   localparam int GAIN_W      = 16;
   localparam int IDX_W       = 8;
   localparam int CLS_IDX_W   = 6;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_PAD_W   = RSP_DATA_W - IDX_W - MAG_W - TAG_W;

   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_COUNT_W     = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_BIN,
      KIND_CLASS
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   index;
      logic [MAG_W-1:0]   level;
      logic [TAG_W-1:0]   peak_tag;
      logic               last;
   } result_type;

   typedef struct packed {
      logic                 valid;
      logic [CLS_IDX_W-1:0] cls;
      logic [MAG_W-1:0]     level;
      logic [TAG_W-1:0]     tag;
   } judge_type;

   typedef struct packed {
      logic active;
      logic pending;
   } dump_status_type;

endpackage

>>> hdl/spcf_class_table.sv
// ----------------------------------------------------------------------------
// spcf_class_table
// Class peak memory: read-modify-write of peak candidates and the frame-end
// dump of all classes, with per-class valid bits that clear after the dump.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcf_class_table #(
   parameter int CLASSES = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spcf_pkg::judge_type       judge,
   input  logic                      dump_go,
   input  logic                      dump_credit,
   output spcf_pkg::dump_status_type dump_status,
   output logic                      dump_valid,
   output spcf_pkg::result_type      dump_entry
);
   import spcf_pkg::*;

   localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam logic [CW-1:0] LAST_CLASS = CW'(CLASSES - 1);

   typedef struct packed {
      logic [MAG_W-1:0] level;
      logic [TAG_W-1:0] tag;
   } entry_type;

   entry_type        table_mem [CLASSES];
   entry_type        rd_ff;

   logic [CLASSES-1:0] valid_ff, valid_in;
   logic             jv_ff, jv_in;
   logic [CW-1:0]    jcls_ff;
   logic [MAG_W-1:0] jlevel_ff;
   logic [TAG_W-1:0] jtag_ff;
   logic             wv_ff, wv_in;
   logic [CW-1:0]    wcls_ff;
   entry_type        wdata_ff;
   logic             dact_ff, dact_in;
   logic [CW-1:0]    dcnt_ff, dcnt_in;
   logic             dv_ff, dv_in;
   logic [CW-1:0]    dcls_ff;
   logic             dlast_ff;
   logic             dok_ff;

   logic             issue;
   logic [CW-1:0]    rd_addr;
   logic             rd_en;
   entry_type        cur;
   logic             wen;
   entry_type        wdata;

   assign issue   = dact_ff && dump_credit;
   assign rd_addr = issue ? dcnt_ff : judge.cls[CW-1:0];
   assign rd_en   = issue || judge.valid;

   // forward the write made on the same edge as the read
   always_comb begin
      if (wv_ff && (wcls_ff == jcls_ff)) begin
         cur = wdata_ff;
      end else if (valid_ff[jcls_ff]) begin
         cur = rd_ff;
      end else begin
         cur = '0;
      end
   end

   assign wen   = jv_ff && (jlevel_ff >= cur.level);
   assign wdata = '{level: jlevel_ff, tag: jtag_ff};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= table_mem[rd_addr];
      end
      if (wen) begin
         table_mem[jcls_ff] <= wdata;
      end
   end

   always_comb begin
      jv_in = judge.valid;
      wv_in = wen;
      dv_in = issue;
   end

   always_comb begin
      valid_in = valid_ff;
      if (dv_ff && dlast_ff) begin
         valid_in = '0;
      end else if (wen) begin
         valid_in[jcls_ff] = 1'b1;
      end
   end

   always_comb begin
      dact_in = dact_ff;
      dcnt_in = dcnt_ff;
      if (dump_go) begin
         dact_in = 1'b1;
         dcnt_in = '0;
      end else if (issue) begin
         if (dcnt_ff == LAST_CLASS) begin
            dact_in = 1'b0;
            dcnt_in = '0;
         end else begin
            dcnt_in = dcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         jv_ff    <= 1'b0;
         wv_ff    <= 1'b0;
         dact_ff  <= 1'b0;
         dcnt_ff  <= '0;
         dv_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         jv_ff    <= jv_in;
         wv_ff    <= wv_in;
         dact_ff  <= dact_in;
         dcnt_ff  <= dcnt_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      jcls_ff   <= judge.cls[CW-1:0];
      jlevel_ff <= judge.level;
      jtag_ff   <= judge.tag;
      wcls_ff   <= jcls_ff;
      wdata_ff  <= wdata;
      if (issue) begin
         dcls_ff  <= dcnt_ff;
         dlast_ff <= (dcnt_ff == LAST_CLASS);
         dok_ff   <= valid_ff[dcnt_ff];
      end
   end

   assign dump_status = '{active: dact_ff, pending: dv_ff};
   assign dump_valid  = dv_ff;

   always_comb begin
      dump_entry.kind     = KIND_CLASS;
      dump_entry.index    = IDX_W'(dcls_ff);
      dump_entry.level    = dok_ff ? rd_ff.level : '0;
      dump_entry.peak_tag = dok_ff ? rd_ff.tag : '0;
      dump_entry.last     = dlast_ff;
   end

   `ASSERT_NEVER(a_judge_during_dump, clock, reset, judge.valid && (dact_ff || dv_ff))
   `ASSERT_NEXT(a_clear_after_dump, clock, reset, dv_ff && dlast_ff, valid_ff == '0)
   `ASSERT_NEVER(a_start_while_dumping, clock, reset, dump_go && (dact_ff || dv_ff))

endmodule

>>> hdl/spcf_rsp_queue.sv
// ----------------------------------------------------------------------------
// spcf_rsp_queue
// Small result queue that decouples the pipeline from response back-pressure.
// ----------------------------------------------------------------------------
module spcf_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_valid,
   input  spcf_pkg::result_type               push_entry,
   input  logic                               pop_ready,
   output logic                               pop_valid,
   output spcf_pkg::result_type               pop_entry,
   output logic [spcf_pkg::RSP_COUNT_W-1:0]   count
);
   import spcf_pkg::*;

   result_type           slot_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_COUNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rptr_ff];
   assign pop       = pop_valid && pop_ready;
   assign count     = count_ff;

   always_comb begin
      wptr_in  = push_valid ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/spectrum_peak_class_folder_unit.sv
// A bin's smoothed result passes stage 1, stage 2 and the result queue. One
// bin per cycle is taken, set by the smoothed-line memory read/write, while
// no class dump runs and the queue has room. A frame end holds the request
// side during the class memory dump, one class per cycle while room lasts.
// Reset clears control state; the smoothed line reads as zero through a fill
// count and the class table through valid bits, so no clearing pass runs.
// ----------------------------------------------------------------------------
// spectrum_peak_class_folder_unit
// Per-bin temporal smoothing, local peak detection and class folding with a
// class table dump at each frame end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_peak_class_folder_unit #(
   parameter int NUM_BINS = 256,
   parameter int CLASSES  = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,  // decay_gain
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // magnitude[31:0], fine_band[43:32], zero pad
   input  logic        req_tlast,    // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // index[7:0], level[39:8], peak_tag[51:40], pad
   output logic        rsp_tlast,    // last_of_run
   output logic        rsp_tuser     // kind
);
   import spcf_pkg::*;

   localparam int PW = $clog2(NUM_BINS);
   localparam int FW = $clog2(NUM_BINS + 1);
   localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int CREDIT_W = RSP_COUNT_W + 1;
   localparam int PROD_W = GAIN_W + MAG_W;

   logic [MAG_W-1:0] smem [NUM_BINS];

   logic [GAIN_W-1:0] decay_ff, decay_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     pcls_ff, pcls_in;
   logic [CW-1:0]     mcls_ff, mcls_in;
   logic [MAG_W-1:0]  prior0_ff, prior0_in;
   logic [MAG_W-1:0]  prior1_ff, prior1_in;
   logic [TAG_W-1:0]  mtag_ff, mtag_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              busy_ff, busy_in;

   logic              s1v_ff;
   logic [PW-1:0]     s1_pos_ff;
   logic [MAG_W-1:0]  s1_mag_ff;
   logic              s1_fend_ff;
   logic              s1_old_ff;
   logic [MAG_W-1:0]  rd_ff;

   logic              s2v_ff;
   logic [PW-1:0]     s2_pos_ff;
   logic [MAG_W-1:0]  s2_mag_ff;
   logic              s2_fend_ff;
   logic [MAG_W-1:0]  s2_prod_ff;

   logic [MAG_W-1:0]  in_mag;
   logic [TAG_W-1:0]  in_tag;
   logic              in_fend;
   logic              req_fire;
   logic              pos_last;
   logic              pcls_last;
   logic [CREDIT_W-1:0] inflight;
   logic              room;

   logic [MAG_W-1:0]  old_val;
   logic [PROD_W-1:0] prod;
   logic [MAG_W:0]    sum;
   logic [MAG_W-1:0]  sat;

   judge_type         judge;
   logic              dump_go;
   dump_status_type   dump_status;
   logic              dump_valid;
   result_type        dump_entry;
   result_type        bin_entry;
   logic              push_valid;
   result_type        push_entry;
   result_type        q_entry;
   logic [RSP_COUNT_W-1:0] q_count;
   logic              q_pop;

   assign in_mag  = req_tdata[MAG_W-1:0];
   assign in_tag  = req_tdata[MAG_W+TAG_W-1:MAG_W];
   assign in_fend = req_tlast;

   assign inflight = CREDIT_W'(q_count) + CREDIT_W'(s1v_ff) + CREDIT_W'(s2v_ff)
                   + CREDIT_W'(dump_status.pending);
   assign room       = inflight < CREDIT_W'(RSP_QUEUE_DEPTH);
   assign req_tready = !busy_ff && room;
   assign req_fire   = req_tvalid && req_tready;

   assign pos_last  = (pos_ff == PW'(NUM_BINS - 1));
   assign pcls_last = (pcls_ff == CW'(CLASSES - 1));

   // the previous bin is judged against its neighbors on arrival of this one
   always_comb begin
      judge.valid = req_fire && (pos_ff >= PW'(2)) && (prior0_ff >= prior1_ff)
                    && (prior0_ff >= in_mag);
      judge.cls   = CLS_IDX_W'(mcls_ff);
      judge.level = prior0_ff;
      judge.tag   = mtag_ff;
   end

   always_comb begin
      decay_in  = csr_wr_en ? csr_wr_data : decay_ff;
      pos_in    = pos_ff;
      pcls_in   = pcls_ff;
      mcls_in   = mcls_ff;
      prior0_in = prior0_ff;
      prior1_in = prior1_ff;
      mtag_in   = mtag_ff;
      fill_in   = fill_ff;
      busy_in   = busy_ff;
      if (req_fire) begin
         if (FW'(pos_ff) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
         if (in_fend) begin
            pos_in    = '0;
            pcls_in   = '0;
            mcls_in   = '0;
            prior0_in = '0;
            prior1_in = '0;
            mtag_in   = '0;
            busy_in   = 1'b1;
         end else begin
            pos_in    = pos_last ? '0 : pos_ff + 1'b1;
            pcls_in   = (pos_last || pcls_last) ? '0 : pcls_ff + 1'b1;
            mcls_in   = pcls_ff;
            prior0_in = in_mag;
            prior1_in = prior0_ff;
            mtag_in   = in_tag;
         end
      end else if (dump_valid && dump_entry.last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= '0;
         pos_ff    <= '0;
         pcls_ff   <= '0;
         mcls_ff   <= '0;
         prior0_ff <= '0;
         prior1_ff <= '0;
         mtag_ff   <= '0;
         fill_ff   <= '0;
         busy_ff   <= 1'b0;
         s1v_ff    <= 1'b0;
         s2v_ff    <= 1'b0;
      end else begin
         decay_ff  <= decay_in;
         pos_ff    <= pos_in;
         pcls_ff   <= pcls_in;
         mcls_ff   <= mcls_in;
         prior0_ff <= prior0_in;
         prior1_ff <= prior1_in;
         mtag_ff   <= mtag_in;
         fill_ff   <= fill_in;
         busy_ff   <= busy_in;
         s1v_ff    <= req_fire;
         s2v_ff    <= s1v_ff;
      end
   end

   // stage 1: stored value times decay
   assign old_val = s1_old_ff ? rd_ff : '0;
   assign prod    = PROD_W'(decay_ff) * PROD_W'(old_val);

   // stage 2: add raw magnitude, saturate
   assign sum = (MAG_W + 1)'(s2_mag_ff) + (MAG_W + 1)'(s2_prod_ff);
   assign sat = sum[MAG_W] ? '1 : sum[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff      <= smem[pos_ff];
         s1_pos_ff  <= pos_ff;
         s1_mag_ff  <= in_mag;
         s1_fend_ff <= in_fend;
         s1_old_ff  <= (FW'(pos_ff) < fill_ff);
      end
      if (s1v_ff) begin
         s2_pos_ff  <= s1_pos_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_fend_ff <= s1_fend_ff;
         s2_prod_ff <= prod[PROD_W-1:GAIN_W];
      end
      if (s2v_ff) begin
         smem[s2_pos_ff] <= sat;
      end
   end

   assign dump_go = s2v_ff && s2_fend_ff;

   spcf_class_table #(
      .CLASSES (CLASSES)
   ) u_class_table (
      .clock       (clock),
      .reset       (reset),
      .judge       (judge),
      .dump_go     (dump_go),
      .dump_credit (room),
      .dump_status (dump_status),
      .dump_valid  (dump_valid),
      .dump_entry  (dump_entry)
   );

   always_comb begin
      bin_entry.kind     = KIND_BIN;
      bin_entry.index    = IDX_W'(s2_pos_ff);
      bin_entry.level    = sat;
      bin_entry.peak_tag = '0;
      bin_entry.last     = !s2_fend_ff;
   end

   assign push_valid = s2v_ff || dump_valid;
   assign push_entry = s2v_ff ? bin_entry : dump_entry;
   assign q_pop      = rsp_tvalid && rsp_tready;

   spcf_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_entry  (q_entry),
      .count      (q_count)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), q_entry.peak_tag, q_entry.level, q_entry.index};
   assign rsp_tlast = q_entry.last;
   assign rsp_tuser = q_entry.kind;

   `ASSERT_NEVER(a_line_addr_overlap, clock, reset, s1v_ff && s2v_ff && (s1_pos_ff == s2_pos_ff))
   `ASSERT_NEVER(a_push_collision, clock, reset, s2v_ff && dump_valid)
   `ASSERT_NEVER(a_queue_overflow, clock, reset, push_valid && !q_pop && (q_count == RSP_COUNT_W'(RSP_QUEUE_DEPTH)))

endmodule

>>> test/tb_spectrum_peak_class_folder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_peak_class_folder_unit
// Streams spectrum bins into the folder and checks every smoothed bin value
// and every class table entry against an in-bench model of the smoothing
// line, the peak judge and the class table, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_spectrum_peak_class_folder_unit;
   import spcf_pkg::*;

   localparam int NUM_BINS = 256;
   localparam int CLASSES  = 12;

   typedef struct {
      kind_type    kind;
      logic [7:0]  index;
      logic [31:0] level;
      logic [11:0] tag;
      logic        last;
   } fold_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   // model state
   logic [15:0] gain;
   logic [31:0] line_level [NUM_BINS];
   logic [31:0] table_level [CLASSES];
   logic [11:0] table_tag [CLASSES];
   logic [31:0] mid_mag, left_mag;
   logic [11:0] mid_tag;
   logic [7:0]  next_pos;

   fold_result_type expected_folds[$];
   int error_count = 0;
   int n_requests  = 0;
   int n_frames    = 0;
   int n_checked   = 0;
   int n_gains     = 0;
   bit idle_on     = 1'b1;
   int stall_left  = 0;

   spectrum_peak_class_folder_unit #(
      .NUM_BINS(NUM_BINS),
      .CLASSES (CLASSES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("spectrum_peak_class_folder_unit: mismatch");
      $finish;
   end

   function automatic int pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_magnitude();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return $urandom;
      if (sel < 65) return $urandom_range(0, 3);
      if (sel < 80) return 32'hFFFF_FFFF - $urandom_range(0, 15);
      return {16'($urandom_range(0, 255)), 16'($urandom)};
   endfunction

   // peak judge, smoothing and class dump for one accepted bin
   task automatic fold_bin(input logic [31:0] mag, input logic [11:0] tag, input logic fend);
      logic [7:0]      pos;
      logic [47:0]     prod;
      logic [32:0]     sum;
      int              cls;
      fold_result_type r;
      pos = next_pos;
      if (pos >= 2 && mid_mag >= left_mag && mid_mag >= mag) begin
         cls = (int'(pos) - 1) % CLASSES;
         if (mid_mag >= table_level[cls]) begin
            table_level[cls] = mid_mag;
            table_tag[cls]   = mid_tag;
         end
      end
      prod = 48'(gain) * 48'(line_level[pos]);
      sum  = 33'(mag) + 33'(prod[47:16]);
      line_level[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      r.kind  = KIND_BIN;
      r.index = pos;
      r.level = line_level[pos];
      r.tag   = '0;
      r.last  = !fend;
      expected_folds.push_back(r);
      if (fend) begin
         for (int c = 0; c < CLASSES; c++) begin
            r.kind  = KIND_CLASS;
            r.index = 8'(c);
            r.level = table_level[c];
            r.tag   = table_tag[c];
            r.last  = (c == CLASSES - 1);
            expected_folds.push_back(r);
            table_level[c] = '0;
            table_tag[c]   = '0;
         end
         mid_mag  = '0;
         left_mag = '0;
         mid_tag  = '0;
         next_pos = '0;
         n_frames++;
      end else begin
         left_mag = mid_mag;
         mid_mag  = mag;
         mid_tag  = tag;
         next_pos = pos + 8'd1;
      end
   endtask

   task automatic send_bin(input logic [31:0] mag, input logic [11:0] tag, input logic fend);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, tag, mag};
      req_tlast  <= fend;
      do @(posedge clock); while (!req_tready);
      fold_bin(mag, tag, fend);
      n_requests++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_folds.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_decay_gain(input logic [15:0] g);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gain = g;
      n_gains++;
   endtask

   task automatic send_random_frame(input int len);
      for (int i = 0; i < len; i++)
         send_bin(pick_magnitude(), 12'($urandom), i == len - 1);
   endtask

   // ---- tests ----

   task automatic test_directed_peaks();
      send_bin(32'd5, 12'h001, 1'b0);
      send_bin(32'd9, 12'h0A5, 1'b0);
      send_bin(32'd9, 12'h05A, 1'b0);
      send_bin(32'd9, 12'h333, 1'b0);
      send_bin(32'hFFFF_FFFF, 12'hFFF, 1'b0);
      send_bin(32'd0, 12'h000, 1'b0);
      send_bin(32'd0, 12'h5A5, 1'b1);
      settle();
   endtask

   task automatic test_short_frames();
      send_bin(32'hFFFF_FFFF, 12'hFFF, 1'b1);
      send_bin(32'h8000_0000, 12'h800, 1'b0);
      send_bin(32'h0000_0001, 12'h001, 1'b1);
      settle();
   endtask

   // bins 1 and 13 share a class with equal peaks; the later tag must win,
   // and bin 13 is judged on the frame end request itself
   task automatic test_class_fold_ties();
      for (int p = 0; p < 15; p++) begin
         if (p == 1)       send_bin(32'd50, 12'h111, 1'b0);
         else if (p == 13) send_bin(32'd50, 12'hEEE, 1'b0);
         else if (p == 14) send_bin(32'd0, 12'($urandom), 1'b1);
         else              send_bin(32'd1, 12'($urandom), 1'b0);
      end
      settle();
   endtask

   task automatic test_saturation();
      set_decay_gain(16'hFFFF);
      send_bin(32'hFFFF_FFFF, 12'hABC, 1'b1);
      send_bin(32'hFFFF_FFFF, 12'h543, 1'b1);
      settle();
   endtask

   // runs past the end of the line: wraps without a frame end
   task automatic test_long_frame();
      set_decay_gain(16'h8000);
      send_random_frame(NUM_BINS + 16);
      settle();
   endtask

   task automatic test_random_frames();
      logic [15:0] gains [5];
      int          sent;
      int unsigned r;
      gains = '{16'hFFFF, 16'h0001, 16'($urandom), 16'h0000, 16'h8000};
      for (int g = 0; g < 5; g++) begin
         idle_on = (g != 4);
         set_decay_gain(gains[g]);
         sent = 0;
         while (sent < 40) begin
            r = $urandom_range(0, 99);
            if (r < 10)      r = $urandom_range(1, 3);
            else if (r < 90) r = $urandom_range(4, 30);
            else             r = $urandom_range(31, 80);
            send_random_frame(r);
            sent += r;
            if ($urandom_range(0, 5) == 0) settle();
         end
      end
      idle_on = 1'b1;
      settle();
   endtask

   // ---- result side ----

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 40)
            $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      fold_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_folds.size() == 0) begin
            error_count++;
            if (error_count <= 40)
               $display("%0t ns: no result expected, actual %h", $time, rsp_tdata);
         end else begin
            want = expected_folds.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("index", 32'(want.index), 32'(rsp_tdata[7:0]));
            check_field("level", want.level, rsp_tdata[39:8]);
            check_field("peak_tag", 32'(want.tag), 32'(rsp_tdata[51:40]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
            n_checked++;
         end
      end
   end

   initial begin
      gain     = '0;
      mid_mag  = '0;
      left_mag = '0;
      mid_tag  = '0;
      next_pos = '0;
      for (int i = 0; i < NUM_BINS; i++) line_level[i] = '0;
      for (int c = 0; c < CLASSES; c++) begin
         table_level[c] = '0;
         table_tag[c]   = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_peaks();
      test_short_frames();
      test_class_fold_ties();
      test_saturation();
      test_long_frame();
      test_random_frames();
      $display("Sent %0d bin requests in %0d frames; %0d results compared.",
               n_requests, n_frames, n_checked);
      $display("Decay gain written %0d times, 0 and 0xFFFF included.", n_gains);
      if (error_count == 0)
         $display("spectrum_peak_class_folder_unit: match");
      else
         $display("spectrum_peak_class_folder_unit: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spcf_pkg.sv
hdl/spcf_class_table.sv
hdl/spcf_rsp_queue.sv
hdl/spectrum_peak_class_folder_unit.sv
test/tb_spectrum_peak_class_folder_unit.sv
